// ===== hdl/m7sap_pkg.sv =====
// m7sap_pkg: shared widths, codes, reset values and stage enables for the
// mode-7 scanline affine parameter core. No dependencies.
package m7sap_pkg;

  // field widths
  localparam int LINE_W     = 8;
  localparam int CAM_W      = 28;
  localparam int HGT_W      = 15;
  localparam int ANG_W      = 8;
  localparam int PIX_W      = 8;
  localparam int ACT_W      = 2;
  localparam int STEP_W     = 16;
  localparam int REF_W      = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  // datapath widths
  localparam int RECIP_W   = 17;         // 65536 / distance, up to 65536
  localparam int LAM_SHIFT = 12;
  localparam int LAM_W     = 19;         // scale after the shift, below 2^19
  localparam int LCF_W     = LAM_W + 2;  // scaled cos / sin, with margin
  localparam int FRAC_SH   = 4;          // step = scaled value >> 4

  // reciprocal numerator
  localparam int RECIP_NUM = 1 << 16;

  // register reset values
  localparam logic [CAM_W-1:0] RST_CAMERA_X      = 28'd2048;
  localparam logic [CAM_W-1:0] RST_CAMERA_Y      = 28'd2048;
  localparam logic [HGT_W-1:0] RST_CAMERA_HEIGHT = 15'd1024;
  localparam logic [ANG_W-1:0] RST_CAMERA_YAW    = 8'd0;
  localparam logic [LINE_W-1:0] RST_HORIZON_LINE = 8'd34;
  localparam logic [PIX_W-1:0] RST_FOCAL         = 8'd128;
  localparam logic [PIX_W-1:0] RST_CENTER_X      = 8'd120;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_X        = 3'd0,
    REG_CAMERA_Y        = 3'd1,
    REG_CAMERA_HEIGHT   = 3'd2,
    REG_CAMERA_YAW      = 3'd3,
    REG_HORIZON_LINE    = 3'd4,
    REG_FOCAL_DISTANCE  = 3'd5,
    REG_SCREEN_CENTER_X = 3'd6
  } cfg_reg_t;

  // per-line action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE    = 2'd0,
    ACT_ENABLE  = 2'd1,
    ACT_PARAMS  = 2'd2,
    ACT_DISABLE = 2'd3
  } line_action_t;

  // pipeline depth and per-stage load enables, stage a in bit 0
  localparam int NUM_STAGES = 8;

  typedef struct packed {
    logic h;
    logic g;
    logic f;
    logic e;
    logic d;
    logic c;
    logic b;
    logic a;
  } stage_en_t;

endpackage

// ===== hdl/m7sap_front.sv =====
// m7sap_front: stages a to c, reciprocal and sine tables, line scale and
// the scale times cos / sin products. Depends on m7sap_pkg.
module m7sap_front #(
  parameter int SINE_ONE = 256,
  localparam int SIN_W = $clog2(SINE_ONE) + 2,
  localparam int PROD_W = m7sap_pkg::LAM_W + 1 + SIN_W
) (
  input  logic                             clk,
  input  m7sap_pkg::stage_en_t             en,
  input  logic [m7sap_pkg::LINE_W-1:0]     scanline,
  input  logic [m7sap_pkg::HGT_W-1:0]      camera_height,
  input  logic [m7sap_pkg::ANG_W-1:0]      camera_yaw,
  input  logic [m7sap_pkg::LINE_W-1:0]     horizon_line,
  output logic signed [PROD_W-1:0]         prod_cos,
  output logic signed [PROD_W-1:0]         prod_sin
);
  import m7sap_pkg::*;

  localparam int NTAB = 1 << ANG_W;
  localparam int QUARTER = NTAB / 4;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1 <<< 30;
  localparam int MUL_W = HGT_W + RECIP_W;

  // sin(idx * pi / 128) in Q30 for idx 0..64, Taylor series in Horner form
  function automatic longint quarter_sine_q30(input longint idx);
    longint x;
    longint x2;
    longint t;
    longint p;
    x = (PI_Q30 * idx) >>> 7;
    x2 = (x * x) >>> 30;
    t = ONE_Q30;
    for (int i = 0; i < 6; i++) begin
      p = (x2 * t) >>> 30;
      case (i)
        0: p = p / 156;
        1: p = p / 110;
        2: p = p / 72;
        3: p = p / 42;
        4: p = p / 20;
        default: p = p / 6;
      endcase
      t = ONE_Q30 - p;
    end
    return (x * t) >>> 30;
  endfunction

  // one entry of the full-turn sine table, rounded to nearest
  function automatic longint sine_entry(input int angle, input int one);
    int a;
    int quad;
    longint idx;
    longint s;
    a = angle & 255;
    quad = a >> 6;
    idx = longint'(a & 63);
    if ((quad & 1) != 0) idx = 64 - idx;
    s = (quarter_sine_q30(idx) * longint'(one) + (ONE_Q30 >>> 1)) >>> 30;
    return (quad >= 2) ? -s : s;
  endfunction

  // constant tables; distance zero (horizon line) reads as distance one
  logic signed [SIN_W-1:0] sine_tbl [NTAB];
  logic [RECIP_W-1:0] recip_tbl [NTAB];

  for (genvar k = 0; k < NTAB; k++) begin : g_tbl
    localparam longint SinVal = sine_entry(k, SINE_ONE);
    localparam int RecipVal = RECIP_NUM / ((k == 0) ? 1 : k);
    assign sine_tbl[k] = SIN_W'(SinVal);
    assign recip_tbl[k] = RECIP_W'(RecipVal);
  end

  logic [LINE_W-1:0] line_dist;
  logic [ANG_W-1:0] cos_idx;
  logic [RECIP_W-1:0] recip_a;
  logic signed [SIN_W-1:0] cos_a;
  logic signed [SIN_W-1:0] sin_a;
  logic signed [SIN_W-1:0] cos_b;
  logic signed [SIN_W-1:0] sin_b;
  logic [MUL_W-1:0] lam_prod;
  logic [LAM_W-1:0] lam_b;

  assign line_dist = scanline - horizon_line;
  assign cos_idx = camera_yaw + ANG_W'(QUARTER);
  assign lam_prod = MUL_W'(camera_height) * MUL_W'(recip_a);

  // stage a: table reads
  always_ff @(posedge clk) begin
    if (en.a) begin
      recip_a <= recip_tbl[line_dist];
      cos_a <= sine_tbl[cos_idx];
      sin_a <= sine_tbl[camera_yaw];
    end
  end

  // stage b: line scale = height * reciprocal >> 12
  always_ff @(posedge clk) begin
    if (en.b) begin
      lam_b <= lam_prod[LAM_SHIFT +: LAM_W];
      cos_b <= cos_a;
      sin_b <= sin_a;
    end
  end

  // stage c: scale times cos and sin, still in sine units
  always_ff @(posedge clk) begin
    if (en.c) begin
      prod_cos <= PROD_W'($signed({1'b0, lam_b})) * PROD_W'(cos_b);
      prod_sin <= PROD_W'($signed({1'b0, lam_b})) * PROD_W'(sin_b);
    end
  end

endmodule

// ===== hdl/m7sap_fdiv.sv =====
// m7sap_fdiv: floor division of a signed product by the sine unit, stages
// d to f: reciprocal multiply, remainder, one-step correction. Uses m7sap_pkg.
module m7sap_fdiv #(
  parameter int SINE_ONE = 256,
  parameter int NUM_W = 30
) (
  input  logic                                clk,
  input  m7sap_pkg::stage_en_t                en,
  input  logic signed [NUM_W-1:0]             num,
  output logic signed [m7sap_pkg::LCF_W-1:0]  quo
);
  import m7sap_pkg::*;

  // |num| stays far below 2^NUM_W, so the estimate is off by one at most
  localparam int SIN_W = $clog2(SINE_ONE) + 2;
  localparam int REM_W = SIN_W + 1;
  localparam int K = NUM_W;
  localparam longint Recip = (64'sd1 <<< K) / SINE_ONE;
  localparam int MW = NUM_W + K - $clog2(SINE_ONE) + 2;
  localparam logic signed [MW-1:0] RecipS = MW'(Recip);
  localparam logic signed [NUM_W-1:0] DivS = NUM_W'(SINE_ONE);
  localparam logic signed [REM_W-1:0] DivR = REM_W'(SINE_ONE);

  logic signed [MW-1:0] est_prod;
  logic signed [LCF_W-1:0] q_d;
  logic signed [NUM_W-1:0] num_d;
  logic signed [NUM_W-1:0] rem_full;
  logic signed [LCF_W-1:0] q_e;
  logic signed [REM_W-1:0] rem_e;

  assign est_prod = MW'(num) * RecipS;
  assign rem_full = num_d - NUM_W'(q_d) * DivS;

  // stage d: quotient estimate by reciprocal multiply
  always_ff @(posedge clk) begin
    if (en.d) begin
      q_d <= est_prod[K +: LCF_W];
      num_d <= num;
    end
  end

  // stage e: remainder of the estimate
  always_ff @(posedge clk) begin
    if (en.e) begin
      q_e <= q_d;
      rem_e <= rem_full[REM_W-1:0];
    end
  end

  // stage f: correct the estimate by one either way
  always_ff @(posedge clk) begin
    if (en.f) begin
      if (rem_e < 0) begin
        quo <= q_e - LCF_W'(1);
      end else if (rem_e >= DivR) begin
        quo <= q_e + LCF_W'(1);
      end else begin
        quo <= q_e;
      end
    end
  end

endmodule

// ===== hdl/m7sap_ref.sv =====
// m7sap_ref: stages g and h, affine steps and line start reference point,
// output word register. Depends on m7sap_pkg.
module m7sap_ref (
  input  logic                                clk,
  input  m7sap_pkg::stage_en_t                en,
  input  logic                                blank,
  input  logic signed [m7sap_pkg::LCF_W-1:0]  lcf,
  input  logic signed [m7sap_pkg::LCF_W-1:0]  lsf,
  input  logic signed [m7sap_pkg::CAM_W-1:0]  camera_x,
  input  logic signed [m7sap_pkg::CAM_W-1:0]  camera_y,
  input  logic [m7sap_pkg::PIX_W-1:0]         focal_distance,
  input  logic [m7sap_pkg::PIX_W-1:0]         screen_center_x,
  output logic signed [m7sap_pkg::STEP_W-1:0] step_x,
  output logic signed [m7sap_pkg::STEP_W-1:0] step_y,
  output logic signed [m7sap_pkg::REF_W-1:0]  ref_x,
  output logic signed [m7sap_pkg::REF_W-1:0]  ref_y
);
  import m7sap_pkg::*;

  localparam int PA_W = LCF_W - FRAC_SH;
  localparam int FD_W = PIX_W + 1 + LCF_W;

  logic signed [PA_W-1:0] pa;
  logic signed [PA_W-1:0] pc;
  logic signed [PA_W-1:0] pa_g;
  logic signed [PA_W-1:0] pc_g;
  logic signed [REF_W-1:0] cxpa_g;
  logic signed [REF_W-1:0] cxpc_g;
  logic signed [FD_W-1:0] fdlsf_g;
  logic signed [FD_W-1:0] fdlcf_g;
  logic signed [REF_W-1:0] cx_s;
  logic signed [FD_W-1:0] fd_s;
  logic signed [REF_W-1:0] rx;
  logic signed [REF_W-1:0] ry;

  assign pa = PA_W'(lcf >>> FRAC_SH);
  assign pc = PA_W'(lsf >>> FRAC_SH);
  assign cx_s = REF_W'(screen_center_x);
  assign fd_s = FD_W'(focal_distance);

  // stage g: centre and forward offset products
  always_ff @(posedge clk) begin
    if (en.g) begin
      pa_g <= pa;
      pc_g <= pc;
      cxpa_g <= cx_s * REF_W'(pa);
      cxpc_g <= cx_s * REF_W'(pc);
      fdlsf_g <= fd_s * FD_W'(lsf);
      fdlcf_g <= fd_s * FD_W'(lcf);
    end
  end

  // reference point, wraps to 28 bits
  assign rx = camera_x - cxpa_g + REF_W'(fdlsf_g >>> FRAC_SH);
  assign ry = camera_y - cxpc_g - REF_W'(fdlcf_g >>> FRAC_SH);

  // stage h: output word, fields cleared on lines without parameters
  always_ff @(posedge clk) begin
    if (en.h) begin
      if (blank) begin
        step_x <= '0;
        step_y <= '0;
        ref_x <= '0;
        ref_y <= '0;
      end else begin
        step_x <= pa_g[STEP_W-1:0];
        step_y <= pc_g[STEP_W-1:0];
        ref_x <= rx;
        ref_y <= ry;
      end
    end
  end

endmodule

// ===== hdl/mode7_scanline_affine_params_core.sv =====
// mode7_scanline_affine_params_core: top level, configuration registers,
// valid / stall pipeline control. Uses m7sap_pkg, m7sap_front, m7sap_fdiv,
// m7sap_ref.
//
//   channel   direction  handshake           payload
//   cfg       in         cfg_we              cfg_index, cfg_data
//   in        in         in_valid/in_stall   scanline
//   out       out        out_valid/out_stall line_action, step_x, step_y,
//                                            ref_x, ref_y
//
// One scanline word enters per cycle while in_stall is low and passes
// through an 8-stage pipeline (tables, scale multiply, sine multiply, three
// division stages, offset multiply, output register).
// Reset clears the valid bits and loads the register reset values.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up and input is taken under out_stall while any stage is empty.
module mode7_scanline_affine_params_core #(
  parameter int VISIBLE_LINES = 160,
  parameter int SINE_ONE = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [m7sap_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [m7sap_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [m7sap_pkg::LINE_W-1:0]         scanline,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [m7sap_pkg::ACT_W-1:0]          line_action,
  output logic signed [m7sap_pkg::STEP_W-1:0]  step_x,
  output logic signed [m7sap_pkg::STEP_W-1:0]  step_y,
  output logic signed [m7sap_pkg::REF_W-1:0]   ref_x,
  output logic signed [m7sap_pkg::REF_W-1:0]   ref_y
);
  import m7sap_pkg::*;

  localparam int SIN_W = $clog2(SINE_ONE) + 2;
  localparam int PROD_W = LAM_W + 1 + SIN_W;
  localparam int ST_G = NUM_STAGES - 2;
  localparam int ST_H = NUM_STAGES - 1;

  // configuration registers
  logic signed [CAM_W-1:0] camera_x;
  logic signed [CAM_W-1:0] camera_y;
  logic [HGT_W-1:0] camera_height;
  logic [ANG_W-1:0] camera_yaw;
  logic [LINE_W-1:0] horizon_line;
  logic [PIX_W-1:0] focal_distance;
  logic [PIX_W-1:0] screen_center_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= RST_CAMERA_X;
      camera_y <= RST_CAMERA_Y;
      camera_height <= RST_CAMERA_HEIGHT;
      camera_yaw <= RST_CAMERA_YAW;
      horizon_line <= RST_HORIZON_LINE;
      focal_distance <= RST_FOCAL;
      screen_center_x <= RST_CENTER_X;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAMERA_X:        camera_x <= cfg_data[CAM_W-1:0];
        REG_CAMERA_Y:        camera_y <= cfg_data[CAM_W-1:0];
        REG_CAMERA_HEIGHT:   camera_height <= cfg_data[HGT_W-1:0];
        REG_CAMERA_YAW:      camera_yaw <= cfg_data[ANG_W-1:0];
        REG_HORIZON_LINE:    horizon_line <= cfg_data[LINE_W-1:0];
        REG_FOCAL_DISTANCE:  focal_distance <= cfg_data[PIX_W-1:0];
        REG_SCREEN_CENTER_X: screen_center_x <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // stage loads: a stage moves when empty or when the next one moves
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] load;
  stage_en_t en;

  always_comb begin
    load[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign en = stage_en_t'(load);
  assign in_stall = !load[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= in_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (load[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // line classification, visible limit checked first
  line_action_t act_in;
  line_action_t act_q [NUM_STAGES];

  always_comb begin
    if (int'(scanline) >= VISIBLE_LINES) begin
      act_in = ACT_DISABLE;
    end else if (scanline < horizon_line) begin
      act_in = ACT_NONE;
    end else if (scanline == horizon_line) begin
      act_in = ACT_ENABLE;
    end else begin
      act_in = ACT_PARAMS;
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) act_q[0] <= act_in;
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (load[i]) act_q[i] <= act_q[i-1];
    end
  end

  logic blank;
  assign blank = (act_q[ST_G] == ACT_NONE) || (act_q[ST_G] == ACT_DISABLE);

  // datapath
  logic signed [PROD_W-1:0] prod_cos;
  logic signed [PROD_W-1:0] prod_sin;
  logic signed [LCF_W-1:0] lcf;
  logic signed [LCF_W-1:0] lsf;

  m7sap_front #(
    .SINE_ONE(SINE_ONE)
  ) u_front (
    .clk(clk),
    .en(en),
    .scanline(scanline),
    .camera_height(camera_height),
    .camera_yaw(camera_yaw),
    .horizon_line(horizon_line),
    .prod_cos(prod_cos),
    .prod_sin(prod_sin)
  );

  m7sap_fdiv #(
    .SINE_ONE(SINE_ONE),
    .NUM_W(PROD_W)
  ) u_div_cos (
    .clk(clk),
    .en(en),
    .num(prod_cos),
    .quo(lcf)
  );

  m7sap_fdiv #(
    .SINE_ONE(SINE_ONE),
    .NUM_W(PROD_W)
  ) u_div_sin (
    .clk(clk),
    .en(en),
    .num(prod_sin),
    .quo(lsf)
  );

  m7sap_ref u_ref (
    .clk(clk),
    .en(en),
    .blank(blank),
    .lcf(lcf),
    .lsf(lsf),
    .camera_x(camera_x),
    .camera_y(camera_y),
    .focal_distance(focal_distance),
    .screen_center_x(screen_center_x),
    .step_x(step_x),
    .step_y(step_y),
    .ref_x(ref_x),
    .ref_y(ref_y)
  );

  assign out_valid = vld[ST_H];
  assign line_action = act_q[ST_H];

  // lines without parameters carry all-zero fields
  a_blank_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (line_action == ACT_NONE || line_action == ACT_DISABLE)
      |-> step_x == '0 && step_y == '0 && ref_x == '0 && ref_y == '0)
    else $error("blank line word carries nonzero fields");

  // an empty output register never holds back the input
  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
